FILE: rtl/core/lru_page_cache_vertex_budget_core_macros.svh
// assertion macros for the lru page cache vertex budget core
`ifndef LRU_PAGE_CACHE_VERTEX_BUDGET_CORE_MACROS_SVH
`define LRU_PAGE_CACHE_VERTEX_BUDGET_CORE_MACROS_SVH

// condition implies check in the same cycle
`define LPCVB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies check in the following cycle
`define LPCVB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/lpcvb_pkg.sv
// shared types and constants of the lru page cache vertex budget core
package lpcvb_pkg;

   localparam int ACTION_W   = 3;
   localparam int PAGE_IDX_W = 5;
   localparam int VTX_W      = 16;
   localparam int TOTAL_W    = 21;
   localparam int KIND_W     = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_VISIT     = 3'd0,
      ACT_LOAD      = 3'd1,
      ACT_DONE      = 3'd2,
      ACT_SET_COUNT = 3'd3,
      ACT_CLEAR     = 3'd4
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE   = 2'd0,
      KIND_EVICT  = 2'd1,
      KIND_ISSUE  = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_EVICT,
      ST_ISSUE
   } state_type;

   typedef struct packed {
      logic             loaded;
      logic             loading;
      logic [VTX_W-1:0] vertices;
   } page_rec_type;

   typedef struct packed {
      logic             lookup;
      logic             shift;
      logic             set_loaded;
      logic             clr_loading;
      logic             set_loading;
      logic             set_count;
      logic             clear_all;
      logic             evict;
      logic [VTX_W-1:0] count;
   } cell_cmd_type;

   typedef struct packed {
      logic                  found;
      logic [PAGE_IDX_W-1:0] page;
      logic [VTX_W-1:0]      vertices;
   } victim_type;

endpackage

FILE: rtl/core/lpcvb_cell.sv
// one recency slot: page id, page record and neighbor chains
module lpcvb_cell
   import lpcvb_pkg::*;
#(
   parameter int ID_W = 5,
   parameter int SLOT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [PAGE_IDX_W-1:0] page,
   input  logic [ID_W-1:0]       left_id,
   input  page_rec_type          left_rec,
   input  logic                  shift_seen_in,
   output logic                  shift_seen_out,
   input  logic                  loaded_seen_in,
   output logic                  loaded_seen_out,
   output logic [ID_W-1:0]       id,
   output page_rec_type          rec,
   output logic                  match,
   output logic                  victim
);

   localparam int CMP_W = (ID_W > PAGE_IDX_W) ? ID_W : PAGE_IDX_W;

   logic [ID_W-1:0] id_ff, id_in;
   page_rec_type    rec_ff, rec_in;
   logic            hit_ff, hit_in;
   logic            shift_en;

   always_comb begin
      match           = (CMP_W'(id_ff) == CMP_W'(page));
      shift_en        = ~shift_seen_in;
      shift_seen_out  = shift_seen_in | hit_ff;
      loaded_seen_out = loaded_seen_in | rec_ff.loaded;
      victim          = rec_ff.loaded & ~loaded_seen_in;

      hit_in = cmd.lookup ? match : hit_ff;
      id_in  = id_ff;
      rec_in = rec_ff;

      // move to front: every slot up to the hit takes its neighbor's entry
      if (cmd.shift && shift_en) begin
         id_in  = left_id;
         rec_in = left_rec;
      end
      if (hit_ff) begin
         if (cmd.set_loaded) begin
            rec_in.loaded = 1'b1;
         end
         if (cmd.clr_loading) begin
            rec_in.loading = 1'b0;
         end
         if (cmd.set_loading) begin
            rec_in.loading = 1'b1;
         end
         if (cmd.set_count) begin
            rec_in.vertices = cmd.count;
         end
      end
      if (cmd.clear_all) begin
         rec_in.loaded = 1'b0;
      end
      if (cmd.evict && victim) begin
         rec_in.loaded = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff  <= ID_W'(SLOT);
         rec_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         id_ff  <= id_in;
         rec_ff <= rec_in;
         hit_ff <= hit_in;
      end
   end

   assign id  = id_ff;
   assign rec = rec_ff;

endmodule

FILE: rtl/core/lpcvb_ctrl.sv
// item sequencer: lookup, apply, eviction walk, result register, budget
`include "lru_page_cache_vertex_budget_core_macros.svh"

module lpcvb_ctrl
   import lpcvb_pkg::*;
#(
   parameter int NUM_PAGES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [PAGE_IDX_W-1:0] req_page_index,
   input  logic [VTX_W-1:0]      req_vertex_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [PAGE_IDX_W-1:0] rsp_result_page,
   output logic [TOTAL_W-1:0]    rsp_cached_total,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [TOTAL_W-1:0]    csr_wr_data,
   input  page_rec_type          lookup_rec,
   input  victim_type            victim,
   output cell_cmd_type          cmd,
   output logic [PAGE_IDX_W-1:0] cell_page,
   output page_rec_type          front_rec
);

   localparam int CMP_W = PAGE_IDX_W + 2;

   state_type             state_ff, state_in;
   logic [ACTION_W-1:0]   action_ff, action_in;
   logic [PAGE_IDX_W-1:0] page_ff, page_in;
   logic [VTX_W-1:0]      count_ff, count_in;
   logic                  valid_page_ff, valid_page_in;
   page_rec_type          rec_ff, rec_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [TOTAL_W-1:0]    budget_ff, budget_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [PAGE_IDX_W-1:0] rsp_page_ff, rsp_page_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic accept;
   logic out_free;
   logic emit;
   logic over_now;
   logic over_after;

   always_comb begin
      accept    = req_valid && (state_ff == ST_IDLE);
      req_stall = (state_ff != ST_IDLE);
      out_free  = ~rsp_valid_ff | ~rsp_stall;
      cell_page = (state_ff == ST_IDLE) ? req_page_index : page_ff;
      front_rec = rec_ff;

      action_in     = accept ? req_action : action_ff;
      page_in       = accept ? req_page_index : page_ff;
      count_in      = accept ? req_vertex_count : count_ff;
      valid_page_in = accept ? (CMP_W'(req_page_index) < CMP_W'(NUM_PAGES)) : valid_page_ff;
      rec_in        = accept ? lookup_rec : rec_ff;
      budget_in     = csr_wr_en ? csr_wr_data : budget_ff;

      over_now   = ((TOTAL_W + 1)'(total_ff) + (TOTAL_W + 1)'(rec_ff.vertices))
                   > (TOTAL_W + 1)'(budget_ff);
      over_after = 1'b0;

      cmd         = '0;
      cmd.count   = count_ff;
      cmd.lookup  = accept;
      state_in    = state_ff;
      total_in    = total_ff;
      emit        = 1'b0;
      rsp_kind_in = KIND_NONE;
      rsp_page_in = '0;
      rsp_last_in = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (action_ff == ACT_CLEAR) begin
                  cmd.clear_all = 1'b1;
                  total_in      = '0;
               end else if (valid_page_ff) begin
                  unique case (action_ff)
                     ACT_VISIT: begin
                        cmd.shift = 1'b1;
                     end
                     ACT_LOAD: begin
                        priority if (rec_ff.loading) begin
                           rsp_kind_in = KIND_NONE;
                        end else if (rec_ff.loaded) begin
                           cmd.clr_loading = 1'b1;
                        end else if (TOTAL_W'(rec_ff.vertices) > budget_ff) begin
                           rsp_kind_in = KIND_REJECT;
                           rsp_page_in = page_ff;
                        end else begin
                           cmd.set_loading = 1'b1;
                           if (over_now) begin
                              emit     = 1'b0;
                              state_in = ST_EVICT;
                           end else begin
                              rsp_kind_in = KIND_ISSUE;
                              rsp_page_in = page_ff;
                           end
                        end
                     end
                     ACT_DONE: begin
                        cmd.set_loaded  = 1'b1;
                        cmd.clr_loading = 1'b1;
                        if (!rec_ff.loaded) begin
                           total_in = total_ff + TOTAL_W'(rec_ff.vertices);
                        end
                     end
                     ACT_SET_COUNT: begin
                        cmd.set_count = 1'b1;
                        if (rec_ff.loaded) begin
                           total_in = total_ff - TOTAL_W'(rec_ff.vertices)
                                      + TOTAL_W'(count_ff);
                        end
                     end
                     default: begin
                        rsp_kind_in = KIND_NONE;
                     end
                  endcase
               end
            end
         end
         ST_EVICT: begin
            if (out_free) begin
               emit = 1'b1;
               if (victim.found) begin
                  cmd.evict   = 1'b1;
                  total_in    = total_ff - TOTAL_W'(victim.vertices);
                  over_after  = ((TOTAL_W + 1)'(total_in) + (TOTAL_W + 1)'(rec_ff.vertices))
                                > (TOTAL_W + 1)'(budget_ff);
                  rsp_kind_in = KIND_EVICT;
                  rsp_page_in = victim.page;
                  rsp_last_in = 1'b0;
                  state_in    = over_after ? ST_EVICT : ST_ISSUE;
               end else begin
                  rsp_kind_in = KIND_ISSUE;
                  rsp_page_in = page_ff;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_ISSUE: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_kind_in = KIND_ISSUE;
               rsp_page_in = page_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_total_in = total_in;
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         budget_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         budget_ff    <= budget_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      page_ff       <= page_in;
      count_ff      <= count_in;
      valid_page_ff <= valid_page_in;
      rec_ff        <= rec_in;
      if (emit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_page_ff  <= rsp_page_in;
         rsp_total_ff <= rsp_total_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_result_page  = rsp_page_ff;
   assign rsp_cached_total = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

   `LPCVB_ASSERT_SAME(a_evict_only_on_load, clock, reset,
      (state_ff == ST_EVICT) || (state_ff == ST_ISSUE), action_ff == ACT_LOAD,
      "eviction walk outside a load request")
   `LPCVB_ASSERT_SAME(a_evict_no_underflow, clock, reset,
      cmd.evict, total_ff >= TOTAL_W'(victim.vertices),
      "evicted vertices exceed the loaded total")
   `LPCVB_ASSERT_SAME(a_evict_not_last, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == KIND_EVICT), !rsp_last_ff,
      "eviction result marked last")
   `LPCVB_ASSERT_NEXT(a_evict_then_issue, clock, reset,
      cmd.evict, (state_ff == ST_EVICT) || (state_ff == ST_ISSUE),
      "load issue lost after an eviction")

endmodule

FILE: rtl/core/lru_page_cache_vertex_budget_core.sv
// LRU page cache with a vertex budget. The pages sit in a chain of slots, front
// slot most recent; each slot holds a page id with its loaded and loading marks
// and vertex count. An item first broadcasts the page to all slots and captures
// its record, then applies the action and writes the result register (a visit
// shifts the chain one step toward the back up to the hit slot and puts the page
// in front). A load request that must make room then walks the evictions, one
// eviction per cycle while rsp_stall does not hold them, each picking the least
// recent loaded slot through a priority chain along the slots, and ends with the
// load result. A result waiting on rsp_stall holds the next item only once it
// blocks a further result. There is no clearing pass after reset.
module lru_page_cache_vertex_budget_core
   import lpcvb_pkg::*;
#(
   parameter int NUM_PAGES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [PAGE_IDX_W-1:0] req_page_index,
   input  logic [VTX_W-1:0]      req_vertex_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [PAGE_IDX_W-1:0] rsp_result_page,
   output logic [TOTAL_W-1:0]    rsp_cached_total,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [TOTAL_W-1:0]    csr_wr_data
);

   localparam int ID_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

   cell_cmd_type          cmd;
   logic [PAGE_IDX_W-1:0] cell_page;
   page_rec_type          front_rec;
   page_rec_type          lookup_rec;
   victim_type            victim;

   logic [ID_W-1:0]       ids       [NUM_PAGES];
   page_rec_type          recs      [NUM_PAGES];
   logic [ID_W-1:0]       left_ids  [NUM_PAGES];
   page_rec_type          left_recs [NUM_PAGES];
   logic [NUM_PAGES-1:0]  hit_vec;
   logic [NUM_PAGES-1:0]  victims;
   logic [NUM_PAGES:0]    shift_chain;
   logic [NUM_PAGES:0]    loaded_chain;
   logic [ID_W-1:0]       victim_id;

   assign shift_chain[0]          = 1'b0;
   assign loaded_chain[NUM_PAGES] = 1'b0;

   for (genvar i = 0; i < NUM_PAGES; i++) begin : g_slot
      if (i == 0) begin : g_front
         assign left_ids[i]  = ID_W'(cell_page);
         assign left_recs[i] = front_rec;
      end else begin : g_inner
         assign left_ids[i]  = ids[i-1];
         assign left_recs[i] = recs[i-1];
      end

      lpcvb_cell #(
         .ID_W (ID_W),
         .SLOT (i)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .cmd             (cmd),
         .page            (cell_page),
         .left_id         (left_ids[i]),
         .left_rec        (left_recs[i]),
         .shift_seen_in   (shift_chain[i]),
         .shift_seen_out  (shift_chain[i+1]),
         .loaded_seen_in  (loaded_chain[i+1]),
         .loaded_seen_out (loaded_chain[i]),
         .id              (ids[i]),
         .rec             (recs[i]),
         .match           (hit_vec[i]),
         .victim          (victims[i])
      );
   end

   // one-hot read buses for the looked-up page and the eviction victim
   always_comb begin
      lookup_rec      = '0;
      victim_id       = '0;
      victim.vertices = '0;
      for (int i = 0; i < NUM_PAGES; i++) begin
         if (hit_vec[i]) begin
            lookup_rec = page_rec_type'(lookup_rec | recs[i]);
         end
         if (victims[i]) begin
            victim_id       = victim_id | ids[i];
            victim.vertices = victim.vertices | recs[i].vertices;
         end
      end
      victim.found = loaded_chain[0];
      victim.page  = PAGE_IDX_W'(victim_id);
   end

   lpcvb_ctrl #(
      .NUM_PAGES (NUM_PAGES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_page_index   (req_page_index),
      .req_vertex_count (req_vertex_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_result_page  (rsp_result_page),
      .rsp_cached_total (rsp_cached_total),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .lookup_rec       (lookup_rec),
      .victim           (victim),
      .cmd              (cmd),
      .cell_page        (cell_page),
      .front_rec        (front_rec)
   );

endmodule

FILE: bench/tb.sv
// testbench for the lru page cache vertex budget core: directed table then random traffic
module tb;
   import lpcvb_pkg::*;

   localparam int PAGES = 32;
   localparam logic [TOTAL_W-1:0] TOTAL_CAP = {TOTAL_W{1'b1}};
   localparam logic [ACTION_W-1:0] ACT_TOP = {ACTION_W{1'b1}};
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 74;

   typedef struct packed {
      kind_type              kind;
      logic [PAGE_IDX_W-1:0] page;
      logic [TOTAL_W-1:0]    total;
      logic                  last;
   } cache_event_type;

   typedef struct {
      bit                    is_cfg;
      logic [ACTION_W-1:0]   act;
      logic [PAGE_IDX_W-1:0] page;
      logic [TOTAL_W-1:0]    value;
      bit                    typed;
      kind_type              kind;
      logic [PAGE_IDX_W-1:0] rpage;
      logic [TOTAL_W-1:0]    total;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ACTION_W-1:0]   req_action = '0;
   logic [PAGE_IDX_W-1:0] req_page_index = '0;
   logic [VTX_W-1:0]      req_vertex_count = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [PAGE_IDX_W-1:0] rsp_result_page;
   logic [TOTAL_W-1:0]    rsp_cached_total;
   logic                  rsp_last;
   logic                  csr_wr_en = 1'b0;
   logic [TOTAL_W-1:0]    csr_wr_data = '0;

   // predicted cache state
   bit                 page_loaded [PAGES];
   bit                 page_loading [PAGES];
   logic [VTX_W-1:0]   page_vtx [PAGES];
   logic [PAGE_IDX_W-1:0] lru_order [PAGES];
   logic [TOTAL_W-1:0] loaded_sum;
   logic [TOTAL_W-1:0] vertex_budget;

   cache_event_type step_events [$];
   cache_event_type events_due [$];
   script_row_type  script [$];
   bit              calm = 1'b0;
   int              failures = 0;
   int              random_sent = 0;

   lru_page_cache_vertex_budget_core #(.NUM_PAGES(PAGES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_page_index(req_page_index),
      .req_vertex_count(req_vertex_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_result_page(rsp_result_page),
      .rsp_cached_total(rsp_cached_total),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 32);
   end

   function automatic void recount_loaded();
      int acc;
      acc = 0;
      for (int i = 0; i < PAGES; i++) begin
         if (page_loaded[i]) begin
            acc += page_vtx[i];
            if (acc > TOTAL_CAP) acc = TOTAL_CAP;
         end
      end
      loaded_sum = TOTAL_W'(acc);
   endfunction

   function automatic void note_event(kind_type k, logic [PAGE_IDX_W-1:0] p);
      cache_event_type ev;
      ev.kind = k;
      ev.page = p;
      ev.total = loaded_sum;
      ev.last = 1'b0;
      step_events.push_back(ev);
   endfunction

   function automatic void move_to_front(logic [PAGE_IDX_W-1:0] p);
      int pos;
      pos = 0;
      while (pos < PAGES && lru_order[pos] != p) pos++;
      if (pos < PAGES) begin
         for (int i = pos; i > 0; i--) lru_order[i] = lru_order[i-1];
         lru_order[0] = p;
      end
   endfunction

   function automatic int evict_lru();
      for (int i = PAGES - 1; i >= 0; i--) begin
         if (page_loaded[lru_order[i]]) begin
            page_loaded[lru_order[i]] = 0;
            recount_loaded();
            return lru_order[i];
         end
      end
      return -1;
   endfunction

   function automatic void predict_cache_action(logic [ACTION_W-1:0] act,
                                                logic [PAGE_IDX_W-1:0] pg,
                                                logic [VTX_W-1:0] cnt);
      int victim;
      step_events.delete();
      case (act)
         ACT_CLEAR: begin
            foreach (page_loaded[i]) page_loaded[i] = 0;
            recount_loaded();
            note_event(KIND_NONE, '0);
         end
         ACT_VISIT: begin
            move_to_front(pg);
            note_event(KIND_NONE, '0);
         end
         ACT_LOAD: begin
            if (page_loading[pg]) begin
               note_event(KIND_NONE, '0);
            end else if (page_loaded[pg]) begin
               page_loading[pg] = 0;
               note_event(KIND_NONE, '0);
            end else if ({5'b0, page_vtx[pg]} > vertex_budget) begin
               note_event(KIND_REJECT, pg);
            end else begin
               page_loading[pg] = 1;
               while ({1'b0, loaded_sum} + page_vtx[pg] > {1'b0, vertex_budget}) begin
                  victim = evict_lru();
                  if (victim < 0) break;
                  note_event(KIND_EVICT, victim[PAGE_IDX_W-1:0]);
               end
               note_event(KIND_ISSUE, pg);
            end
         end
         ACT_DONE: begin
            page_loaded[pg] = 1;
            page_loading[pg] = 0;
            recount_loaded();
            note_event(KIND_NONE, '0);
         end
         ACT_SET_COUNT: begin
            page_vtx[pg] = cnt;
            recount_loaded();
            note_event(KIND_NONE, '0);
         end
         default: note_event(KIND_NONE, '0);
      endcase
      step_events[step_events.size()-1].last = 1'b1;
   endfunction

   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [PAGE_IDX_W-1:0] pg,
                            input logic [VTX_W-1:0] cnt, input bit typed,
                            input cache_event_type want);
      while (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_page_index <= pg;
      req_vertex_count <= cnt;
      do @(posedge clock); while (req_stall);
      predict_cache_action(act, pg, cnt);
      if (typed) begin
         want.last = 1'b1;
         events_due.push_back(want);
      end else begin
         foreach (step_events[i]) events_due.push_back(step_events[i]);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_budget(input logic [TOTAL_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vertex_budget = v;
   endtask

   function automatic void row(bit is_cfg, logic [ACTION_W-1:0] act,
                               logic [PAGE_IDX_W-1:0] pg, logic [TOTAL_W-1:0] value,
                               bit typed, kind_type k, logic [PAGE_IDX_W-1:0] rpage,
                               logic [TOTAL_W-1:0] total);
      script_row_type r;
      r.is_cfg = is_cfg;
      r.act = act;
      r.page = pg;
      r.value = value;
      r.typed = typed;
      r.kind = k;
      r.rpage = rpage;
      r.total = total;
      script.push_back(r);
   endfunction

   function automatic logic [VTX_W-1:0] pick_count();
      int lim;
      lim = vertex_budget / 3;
      if (lim > 65535) lim = 65535;
      if (lim < 1) lim = 1;
      case ($urandom_range(9))
         0: return '0;
         1: return {VTX_W{1'b1}};
         2, 3: return VTX_W'($urandom_range(65535));
         default: return VTX_W'($urandom_range(lim));
      endcase
   endfunction

   task automatic random_item(input logic [PAGE_IDX_W-1:0] hot_base);
      logic [PAGE_IDX_W-1:0] pg;
      logic [ACTION_W-1:0]   act;
      int                    sel;
      int                    pending [$];
      cache_event_type       none;
      none = '0;
      pg = ($urandom_range(99) < 70) ? PAGE_IDX_W'(hot_base + $urandom_range(7))
                                     : PAGE_IDX_W'($urandom_range(31));
      sel = $urandom_range(99);
      if (sel < 20) act = ACT_VISIT;
      else if (sel < 50) act = ACT_LOAD;
      else if (sel < 75) begin
         act = ACT_DONE;
         foreach (page_loading[i]) if (page_loading[i]) pending.push_back(i);
         if (pending.size() != 0 && $urandom_range(99) < 80)
            pg = PAGE_IDX_W'(pending[$urandom_range(pending.size() - 1)]);
      end else if (sel < 92) act = ACT_SET_COUNT;
      else if (sel < 96) act = ACT_CLEAR;
      else act = ACTION_W'($urandom_range(ACT_CLEAR + 1, ACT_TOP));
      calm = (random_sent >= 150 && random_sent < 260);
      send_item(act, pg, pick_count(), 1'b0, none);
      random_sent++;
   endtask

   // result checker
   always @(posedge clock) begin
      cache_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (events_due.size() == 0) begin
            $display("%0t: unexpected result kind %0d page %0d total %0d", $time,
                     rsp_kind, rsp_result_page, rsp_cached_total);
            failures++;
         end else begin
            want = events_due.pop_front();
            if (rsp_kind !== want.kind) begin
               $display("%0t: rsp_kind expected %0d actual %0d", $time, want.kind, rsp_kind);
               failures++;
            end
            if (rsp_result_page !== want.page) begin
               $display("%0t: rsp_result_page expected %0d actual %0d", $time,
                        want.page, rsp_result_page);
               failures++;
            end
            if (rsp_cached_total !== want.total) begin
               $display("%0t: rsp_cached_total expected %0d actual %0d", $time,
                        want.total, rsp_cached_total);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: rsp_last expected %0d actual %0d", $time, want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   initial begin
      #10000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      cache_event_type       want;
      logic [TOTAL_W-1:0]    budgets [RANDOM_PHASES];
      logic [PAGE_IDX_W-1:0] hot_base;

      vertex_budget = TOTAL_CAP;
      loaded_sum = '0;
      foreach (lru_order[i]) begin
         page_loaded[i] = 0;
         page_loading[i] = 0;
         page_vtx[i] = '0;
         lru_order[i] = PAGE_IDX_W'(i);
      end

      // budget at its reset value
      row(0, ACT_VISIT, 0, 0, 1, KIND_NONE, 0, 0);
      row(0, ACT_VISIT, 31, 0, 1, KIND_NONE, 0, 0);
      row(0, ACT_SET_COUNT, 31, 65535, 1, KIND_NONE, 0, 0);
      row(0, ACT_LOAD, 31, 0, 1, KIND_ISSUE, 31, 0);
      row(0, ACT_LOAD, 31, 0, 1, KIND_NONE, 0, 0);
      row(0, ACT_DONE, 31, 0, 1, KIND_NONE, 0, 65535);
      row(0, ACT_LOAD, 31, 0, 1, KIND_NONE, 0, 65535);
      row(0, ACT_DONE, 31, 0, 1, KIND_NONE, 0, 65535);
      row(0, ACT_DONE, 0, 0, 1, KIND_NONE, 0, 65535);
      row(0, ACTION_W'(ACT_CLEAR + 1), 7, 0, 1, KIND_NONE, 0, 65535);
      row(0, ACT_TOP, 31, 65535, 1, KIND_NONE, 0, 65535);
      row(0, ACT_LOAD, 5, 0, 0, KIND_NONE, 0, 0);
      row(0, ACT_CLEAR, 0, 0, 1, KIND_NONE, 0, 0);
      // small budget
      row(1, ACT_VISIT, 0, 100, 0, KIND_NONE, 0, 0);
      row(0, ACT_SET_COUNT, 1, 60, 0, KIND_NONE, 0, 0);
      row(0, ACT_SET_COUNT, 2, 50, 0, KIND_NONE, 0, 0);
      row(0, ACT_SET_COUNT, 3, 101, 0, KIND_NONE, 0, 0);
      row(0, ACT_LOAD, 3, 0, 1, KIND_REJECT, 3, 0);
      row(0, ACT_LOAD, 1, 0, 0, KIND_NONE, 0, 0);
      row(0, ACT_DONE, 1, 0, 0, KIND_NONE, 0, 0);
      row(0, ACT_LOAD, 2, 0, 0, KIND_NONE, 0, 0);
      row(0, ACT_DONE, 2, 0, 0, KIND_NONE, 0, 0);
      row(0, ACT_VISIT, 1, 0, 0, KIND_NONE, 0, 0);
      row(0, ACT_DONE, 1, 0, 0, KIND_NONE, 0, 0);
      row(0, ACT_SET_COUNT, 2, 65535, 0, KIND_NONE, 0, 0);
      row(0, ACT_LOAD, 4, 0, 0, KIND_NONE, 0, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            write_budget(script[i].value);
         end else begin
            want.kind = script[i].kind;
            want.page = script[i].rpage;
            want.total = script[i].total;
            want.last = 1'b1;
            send_item(script[i].act, script[i].page, script[i].value[VTX_W-1:0],
                      script[i].typed, want);
         end
      end

      budgets[0] = 1;
      budgets[1] = TOTAL_CAP;
      budgets[2] = TOTAL_W'($urandom_range(1, TOTAL_CAP));
      budgets[3] = 150;
      budgets[4] = TOTAL_W'($urandom_range(1000, 300000));
      budgets[5] = 65535;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_budget(budgets[ph]);
         hot_base = PAGE_IDX_W'($urandom_range(31));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item(hot_base);
      end
      calm = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
